>>> rtl/tensor_permute_address_gen_macros.svh
// Assertion macros shared by the tensor permute address generator RTL.
`ifndef TENSOR_PERMUTE_ADDRESS_GEN_MACROS_SVH
`define TENSOR_PERMUTE_ADDRESS_GEN_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, switched off while reset is asserted.
`define TPAG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define TPAG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TPAG_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPAG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/tpag_pkg.sv
// Package with register indexes, field widths and reset values of the address generator.
package tpag_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  // Register field widths.
  localparam int NUM_DIMS_BITS = 3;
  localparam int PERM_MAP_BITS = 8;
  localparam int PERM_BITS     = 2;
  localparam int STRIDE_BITS   = 32;
  localparam int PACKED_DIMS   = 4;

  // Width of the offset fields on the result channel.
  localparam int FIELD_OFFSET_BITS = 32;

  // Register reset values.
  localparam logic [NUM_DIMS_BITS-1:0] NUM_DIMS_RST  = 3'd1;
  localparam logic [CFG_DATA_BITS-1:0] DIM_SIZES_RST = 64'h0001_0001_0001_0001;
  localparam logic [CFG_DATA_BITS-1:0] STRIDES_RST   = 64'h0;
  localparam logic [PERM_MAP_BITS-1:0] PERM_MAP_RST  = 8'hE4;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NUM_DIMS         = 3'd0,
    CFG_DIM_SIZES        = 3'd1,
    CFG_IN_STRIDES_LOW   = 3'd2,
    CFG_IN_STRIDES_HIGH  = 3'd3,
    CFG_OUT_STRIDES_LOW  = 3'd4,
    CFG_OUT_STRIDES_HIGH = 3'd5,
    CFG_PERM_MAP         = 3'd6
  } cfg_idx_e;

endpackage

>>> rtl/tpag_odometer.sv
// Coordinate odometer: holds the input coordinates and advances them once per transfer.
module tpag_odometer import tpag_pkg::*; #(
  parameter int MAX_DIMS  = 4,
  parameter int SIZE_BITS = 16,
  localparam int ND_BITS  = $clog2(MAX_DIMS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               restart_i,
  input  logic [NUM_DIMS_BITS-1:0]           num_dims_i,
  input  logic [CFG_DATA_BITS-1:0]           dim_sizes_i,
  output logic [ND_BITS-1:0]                 nd_o,
  output logic [MAX_DIMS-1:0][SIZE_BITS-1:0] coord_o,
  output logic                               final_o
);

  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] coord_q, coord_d;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] size;
  logic [MAX_DIMS:0]                  carry;
  logic [ND_BITS-1:0]                 nd;

  // Dimensions in use: zero counts as one, and the count saturates at the maximum.
  always_comb begin
    if (num_dims_i == '0) begin
      nd = ND_BITS'(1);
    end else if (int'(num_dims_i) > MAX_DIMS) begin
      nd = ND_BITS'(MAX_DIMS);
    end else begin
      nd = ND_BITS'(num_dims_i);
    end
  end

  // Unpack the sizes; dimensions beyond the packed register have size one.
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_size
    if (d * SIZE_BITS < CFG_DATA_BITS) begin : g_packed
      logic [CFG_DATA_BITS-1:0] shifted;
      assign shifted = dim_sizes_i >> (d * SIZE_BITS);
      assign size[d] = shifted[SIZE_BITS-1:0];
    end else begin : g_unpacked
      assign size[d] = SIZE_BITS'(1);
    end
  end

  // Ripple the carry from dimension 0 upwards. A size of zero wraps like a size of one.
  always_comb begin
    logic [SIZE_BITS:0] inc;
    logic               wrap;
    carry[0] = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      coord_o[d] = restart_i ? '0 : coord_q[d];
      inc        = {1'b0, coord_o[d]} + (SIZE_BITS + 1)'(1);
      wrap       = inc >= {1'b0, size[d]};
      coord_d[d] = coord_o[d];
      if ((d < int'(nd)) && carry[d]) begin
        coord_d[d] = wrap ? '0 : inc[SIZE_BITS-1:0];
      end
      carry[d+1] = carry[d] && ((d >= int'(nd)) || wrap);
    end
  end

  assign nd_o    = nd;
  assign final_o = carry[MAX_DIMS];

  // Coordinate registers move on every accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
    end else if (adv_i) begin
      coord_q <= coord_d;
    end
  end

endmodule

>>> rtl/tensor_permute_address_gen.sv
// Top level of the N-dimensional tensor permute address generator.
//
// Each transfer on the request channel (valid_i, stall_o, restart_i) yields one transfer
// on the result channel (valid_o, stall_i) carrying the source byte offset, the
// destination byte offset of the permuted element and a flag on the last element.
// restart_i set clears the coordinates before that element is produced; after the
// last element the coordinates wrap to zero on their own.
// The block takes one request per cycle while stall_o is low. The pipeline has two
// registers: the coordinate capture, and the result register fed by one multiplier per
// stride lane and the offset adder. An accepted request moves from the coordinate capture
// to the result register; unstalled back-to-back requests give back-to-back results.
// When the receiver stalls, the pipeline fills up and stall_o rises once both
// stages hold an item; no item is dropped or repeated.
// The configuration port (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) is always
// ready; the user must write it only while no item is in flight, as the block does not enforce it.
// Reset clears the coordinates, empties the pipeline and restores the registers to one
// dimension of size one, zero strides and the identity permutation.
`include "tensor_permute_address_gen_macros.svh"

module tensor_permute_address_gen import tpag_pkg::*; #(
  parameter int MAX_DIMS    = 4,
  parameter int SIZE_BITS   = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data_i,
  // Request channel.
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic                         restart_i,
  // Result channel.
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [FIELD_OFFSET_BITS-1:0] src_offset_o,
  output logic [FIELD_OFFSET_BITS-1:0] dst_offset_o,
  output logic                         final_element_o
);

  localparam int ACC_BITS  = (OFFSET_BITS < FIELD_OFFSET_BITS) ? OFFSET_BITS
                                                               : FIELD_OFFSET_BITS;
  localparam int PROD_BITS = SIZE_BITS + STRIDE_BITS;
  localparam int ND_BITS   = $clog2(MAX_DIMS + 1);

  // Configuration registers.
  logic [NUM_DIMS_BITS-1:0] num_dims_q;
  logic [CFG_DATA_BITS-1:0] dim_sizes_q;
  logic [CFG_DATA_BITS-1:0] in_strides_low_q, in_strides_high_q;
  logic [CFG_DATA_BITS-1:0] out_strides_low_q, out_strides_high_q;
  logic [PERM_MAP_BITS-1:0] perm_map_q;

  // Odometer interface.
  logic                               accept;
  logic [ND_BITS-1:0]                 nd;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] coord;
  logic                               odo_final;

  // Pipeline stages.
  logic                               v1_q, valid_q;
  logic                               rdy1, rdy2;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] src_c_d, dst_c_d, src_c_q, dst_c_q;
  logic                               final1_q, final2_q;
  logic [MAX_DIMS-1:0][ACC_BITS-1:0]  in_prod, out_prod;
  logic [ACC_BITS-1:0]                src_sum, dst_sum, src_q, dst_q;
  logic [MAX_DIMS-1:0][STRIDE_BITS-1:0] in_stride, out_stride;

  // Register writes are always taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q         <= NUM_DIMS_RST;
      dim_sizes_q        <= DIM_SIZES_RST;
      in_strides_low_q   <= STRIDES_RST;
      in_strides_high_q  <= STRIDES_RST;
      out_strides_low_q  <= STRIDES_RST;
      out_strides_high_q <= STRIDES_RST;
      perm_map_q         <= PERM_MAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_DIMS:         num_dims_q         <= cfg_data_i[NUM_DIMS_BITS-1:0];
        CFG_DIM_SIZES:        dim_sizes_q        <= cfg_data_i;
        CFG_IN_STRIDES_LOW:   in_strides_low_q   <= cfg_data_i;
        CFG_IN_STRIDES_HIGH:  in_strides_high_q  <= cfg_data_i;
        CFG_OUT_STRIDES_LOW:  out_strides_low_q  <= cfg_data_i;
        CFG_OUT_STRIDES_HIGH: out_strides_high_q <= cfg_data_i;
        CFG_PERM_MAP:         perm_map_q         <= cfg_data_i[PERM_MAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage moves when it is empty or its successor moves.
  assign rdy2    = !valid_q || !stall_i;
  assign rdy1    = !v1_q || rdy2;
  assign stall_o = !rdy1;
  assign accept  = valid_i && !stall_o;

  tpag_odometer #(
    .MAX_DIMS  (MAX_DIMS),
    .SIZE_BITS (SIZE_BITS)
  ) u_odometer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (accept),
    .restart_i   (restart_i),
    .num_dims_i  (num_dims_q),
    .dim_sizes_i (dim_sizes_q),
    .nd_o        (nd),
    .coord_o     (coord),
    .final_o     (odo_final)
  );

  // Source coordinates in use, and the permuted coordinates for the destination.
  always_comb begin
    logic [NUM_DIMS_BITS-1:0] p;
    for (int i = 0; i < MAX_DIMS; i++) begin
      src_c_d[i] = (i < int'(nd)) ? coord[i] : '0;
      if (i < PACKED_DIMS) begin
        p = NUM_DIMS_BITS'(perm_map_q[i*PERM_BITS +: PERM_BITS]);
      end else begin
        p = NUM_DIMS_BITS'(i);
      end
      dst_c_d[i] = '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
        if ((int'(p) == j) && (i < int'(nd)) && (j < int'(nd))) begin
          dst_c_d[i] = coord[j];
        end
      end
    end
  end

  // Stage 1: capture the coordinates of the accepted element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_c_q  <= src_c_d;
      dst_c_q  <= dst_c_d;
      final1_q <= odo_final;
    end
  end

  // Stride lanes; dimensions beyond the packed registers have stride zero.
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    logic [PROD_BITS-1:0] in_full, out_full;
    if (d < PACKED_DIMS) begin : g_stride
      localparam int LO = (d % 2) * STRIDE_BITS;
      if (d < 2) begin : g_low
        assign in_stride[d]  = in_strides_low_q[LO +: STRIDE_BITS];
        assign out_stride[d] = out_strides_low_q[LO +: STRIDE_BITS];
      end else begin : g_high
        assign in_stride[d]  = in_strides_high_q[LO +: STRIDE_BITS];
        assign out_stride[d] = out_strides_high_q[LO +: STRIDE_BITS];
      end
    end else begin : g_zero
      assign in_stride[d]  = '0;
      assign out_stride[d] = '0;
    end
    assign in_full     = PROD_BITS'(src_c_q[d]) * PROD_BITS'(in_stride[d]);
    assign out_full    = PROD_BITS'(dst_c_q[d]) * PROD_BITS'(out_stride[d]);
    assign in_prod[d]  = in_full[ACC_BITS-1:0];
    assign out_prod[d] = out_full[ACC_BITS-1:0];
  end

  // Offset sums wrap at the offset width.
  always_comb begin
    src_sum = '0;
    dst_sum = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      src_sum = src_sum + in_prod[d];
      dst_sum = dst_sum + out_prod[d];
    end
  end

  // Stage 2: result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy2) begin
      valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      src_q    <= src_sum;
      dst_q    <= dst_sum;
      final2_q <= final1_q;
    end
  end

  assign valid_o         = valid_q;
  assign src_offset_o    = FIELD_OFFSET_BITS'(src_q);
  assign dst_offset_o    = FIELD_OFFSET_BITS'(dst_q);
  assign final_element_o = final2_q;

  // Requests are held off only when every stage holds an item.
  `TPAG_ASSERT(a_stall_when_full, clk_i, rst_ni, stall_o |-> (v1_q && valid_q), "stall, stage free")
  // A blocked capture stage keeps its item.
  `TPAG_ASSERT(a_stage1_holds, clk_i, rst_ni, (v1_q && !rdy2) |=> v1_q, "blocked stage lost item")
  // Reset empties the result register.
  `TPAG_ASSERT_ALWAYS(a_reset_empties, clk_i, !rst_ni |=> !valid_o, "result valid after reset")

endmodule

>>> dv/tensor_permute_address_gen_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tensor permute address generator, with its own offset predictor.
module tensor_permute_address_gen_tb;
  import tpag_pkg::*;

  localparam int DIMS = PACKED_DIMS;
  localparam int SIZE_W = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT = 2000;
  // An index that names no register; writes to it must leave everything unchanged.
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic [FIELD_OFFSET_BITS-1:0] src;
    logic [FIELD_OFFSET_BITS-1:0] dst;
    logic                         last_elem;
  } offsets_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_CHK} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    logic                     restart;
    offsets_t                 result;
  } script_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]      cfg_index_i;
  logic [CFG_DATA_BITS-1:0]     cfg_data_i;
  logic                         valid_i;
  logic                         stall_o;
  logic                         restart_i;
  logic                         valid_o;
  logic                         stall_i;
  logic [FIELD_OFFSET_BITS-1:0] src_offset_o;
  logic [FIELD_OFFSET_BITS-1:0] dst_offset_o;
  logic                         final_element_o;

  // Mirror of the register file and the coordinate odometer.
  logic [NUM_DIMS_BITS-1:0] mirror_num_dims;
  logic [CFG_DATA_BITS-1:0] mirror_sizes;
  logic [CFG_DATA_BITS-1:0] mirror_in_lo;
  logic [CFG_DATA_BITS-1:0] mirror_in_hi;
  logic [CFG_DATA_BITS-1:0] mirror_out_lo;
  logic [CFG_DATA_BITS-1:0] mirror_out_hi;
  logic [PERM_MAP_BITS-1:0] mirror_perm;
  logic [SIZE_W-1:0]        odometer [DIMS];

  offsets_t    pending_offsets[$];
  offsets_t    oldest_offsets;
  script_row_t directed_table[$];

  int fail_count;
  int results_checked;
  int last_flags_seen;
  int settings_count;
  int quiet_items;
  int idle_cycles;

  tensor_permute_address_gen DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .restart_i      (restart_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .src_offset_o   (src_offset_o),
    .dst_offset_o   (dst_offset_o),
    .final_element_o(final_element_o)
  );

  // 100 MHz clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stride lane d of a pair of packed stride registers.
  function automatic logic [STRIDE_BITS-1:0] stride_lane(input logic [CFG_DATA_BITS-1:0] lo,
                                                         input logic [CFG_DATA_BITS-1:0] hi,
                                                         input int d);
    return (d < 2) ? lo[STRIDE_BITS*d +: STRIDE_BITS] : hi[STRIDE_BITS*(d-2) +: STRIDE_BITS];
  endfunction

  // Size of dimension d, where a size of zero behaves as one.
  function automatic int dim_extent(input int d);
    logic [SIZE_W-1:0] s;
    s = mirror_sizes[SIZE_W*d +: SIZE_W];
    return (s == '0) ? 1 : int'(s);
  endfunction

  // Offsets of the current element, then one step of the odometer.
  function automatic offsets_t step_odometer(input logic restart);
    int                           active;
    int                           src_dim;
    logic [FIELD_OFFSET_BITS-1:0] coord_val;
    logic [FIELD_OFFSET_BITS-1:0] src_sum;
    logic [FIELD_OFFSET_BITS-1:0] dst_sum;
    bit                           carry;
    offsets_t                     res;
    if (restart) begin
      for (int d = 0; d < DIMS; d++) odometer[d] = '0;
    end
    active = (mirror_num_dims == '0) ? 1 :
             (int'(mirror_num_dims) > DIMS) ? DIMS : int'(mirror_num_dims);
    src_sum = '0;
    dst_sum = '0;
    for (int d = 0; d < active; d++) begin
      coord_val = FIELD_OFFSET_BITS'(odometer[d]);
      src_sum += coord_val * stride_lane(mirror_in_lo, mirror_in_hi, d);
    end
    // Output dimension d reads the input coordinate that the permutation names.
    for (int d = 0; d < active; d++) begin
      src_dim = int'(mirror_perm[PERM_BITS*d +: PERM_BITS]);
      coord_val = (src_dim < active) ? FIELD_OFFSET_BITS'(odometer[src_dim]) : '0;
      dst_sum += coord_val * stride_lane(mirror_out_lo, mirror_out_hi, d);
    end
    // A coordinate at or past its size wraps and carries into the next dimension.
    carry = 1'b1;
    for (int d = 0; d < active && carry; d++) begin
      if (int'(odometer[d]) + 1 >= dim_extent(d)) begin
        odometer[d] = '0;
      end else begin
        odometer[d] = odometer[d] + 1'b1;
        carry = 1'b0;
      end
    end
    res.src = src_sum;
    res.dst = dst_sum;
    res.last_elem = carry;
    return res;
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] index,
                                          input logic [CFG_DATA_BITS-1:0] data);
    script_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.index = index;
    row.data = data;
    return row;
  endfunction

  function automatic script_row_t req_row(input logic restart);
    script_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.restart = restart;
    return row;
  endfunction

  function automatic script_row_t chk_row(input logic restart,
                                          input logic [FIELD_OFFSET_BITS-1:0] src,
                                          input logic [FIELD_OFFSET_BITS-1:0] dst,
                                          input logic last_elem);
    script_row_t row;
    row = '0;
    row.kind = ROW_CHK;
    row.restart = restart;
    row.result = '{src: src, dst: dst, last_elem: last_elem};
    return row;
  endfunction

  // Sender gap: mostly none, a few long, with occasional runs of back-to-back requests.
  function automatic int pick_gap();
    int r;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet_items = $urandom_range(30, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [STRIDE_BITS-1:0] pick_stride();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return STRIDE_BITS'($urandom_range(1, 64));
      default: return STRIDE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input bit wide);
    int r;
    r = $urandom_range(0, 15);
    if (wide) return SIZE_W'($urandom);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SIZE_W'($urandom_range(1, 4));
  endfunction

  // One register write transfer; the mirror follows at the accepting edge.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (index)
      CFG_NUM_DIMS:         mirror_num_dims = data[NUM_DIMS_BITS-1:0];
      CFG_DIM_SIZES:        mirror_sizes = data;
      CFG_IN_STRIDES_LOW:   mirror_in_lo = data;
      CFG_IN_STRIDES_HIGH:  mirror_in_hi = data;
      CFG_OUT_STRIDES_LOW:  mirror_out_lo = data;
      CFG_OUT_STRIDES_HIGH: mirror_out_hi = data;
      CFG_PERM_MAP:         mirror_perm = data[PERM_MAP_BITS-1:0];
      default:              ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One request transfer, preceded by a random gap.
  task automatic send_request(input logic restart, input bit typed, input offsets_t typed_val);
    int       gap;
    offsets_t predicted;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      valid_i = 1'b0;
      restart_i = 1'($urandom_range(0, 1));
    end
    @(negedge clk_i);
    valid_i = 1'b1;
    restart_i = restart;
    forever begin
      @(posedge clk_i);
      if (!stall_o) break;
    end
    predicted = step_odometer(restart);
    pending_offsets.push_back(typed ? typed_val : predicted);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain_pipeline();
    @(negedge clk_i);
    valid_i = 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // New random setting of every register; a few settings use wide sizes.
  task automatic randomise_config();
    logic [CFG_DATA_BITS-1:0] data;
    bit                       wide;
    wide = ($urandom_range(0, 9) == 0);
    data = {$urandom, $urandom};
    data[NUM_DIMS_BITS-1:0] = NUM_DIMS_BITS'($urandom_range(0, 7));
    write_register(CFG_NUM_DIMS, data);
    for (int d = 0; d < DIMS; d++) data[SIZE_W*d +: SIZE_W] = pick_size(wide);
    write_register(CFG_DIM_SIZES, data);
    write_register(CFG_IN_STRIDES_LOW, {pick_stride(), pick_stride()});
    write_register(CFG_IN_STRIDES_HIGH, {pick_stride(), pick_stride()});
    write_register(CFG_OUT_STRIDES_LOW, {pick_stride(), pick_stride()});
    write_register(CFG_OUT_STRIDES_HIGH, {pick_stride(), pick_stride()});
    write_register(CFG_PERM_MAP, {$urandom, $urandom});
    settings_count++;
  endtask

  // Result receiver: random stall, mostly short, sometimes long, with long calm runs.
  initial begin
    int calm;
    int hold;
    stall_i = 1'b0;
    forever begin
      calm = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      repeat (calm) @(negedge clk_i) stall_i = 1'b0;
      repeat (hold) @(negedge clk_i) stall_i = 1'b1;
    end
  end

  // Compare each result transfer with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_offsets.size() == 0) begin
        $error("result transfer with no request outstanding");
        fail_count++;
      end else begin
        oldest_offsets = pending_offsets.pop_front();
        results_checked++;
        if (final_element_o === 1'b1) last_flags_seen++;
        if (src_offset_o !== oldest_offsets.src) begin
          $error("src_offset: expected %h, got %h", oldest_offsets.src, src_offset_o);
          fail_count++;
        end
        if (dst_offset_o !== oldest_offsets.dst) begin
          $error("dst_offset: expected %h, got %h", oldest_offsets.dst, dst_offset_o);
          fail_count++;
        end
        if (final_element_o !== oldest_offsets.last_elem) begin
          $error("final_element: expected %b, got %b", oldest_offsets.last_elem,
                 final_element_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results outstanding", idle_cycles,
               pending_offsets.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final drain.
  initial begin
    int phase;
    int burst;
    int random_sent;
    int directed_sent;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    valid_i = 1'b0;
    restart_i = 1'b0;
    fail_count = 0;
    results_checked = 0;
    last_flags_seen = 0;
    settings_count = 1;
    quiet_items = 0;
    idle_cycles = 0;
    mirror_num_dims = NUM_DIMS_RST;
    mirror_sizes = DIM_SIZES_RST;
    mirror_in_lo = STRIDES_RST;
    mirror_in_hi = STRIDES_RST;
    mirror_out_lo = STRIDES_RST;
    mirror_out_hi = STRIDES_RST;
    mirror_perm = PERM_MAP_RST;
    for (int d = 0; d < DIMS; d++) odometer[d] = '0;

    directed_table = '{
      // Reset state: a single element of size one with zero strides.
      chk_row(1'b0, 32'h0, 32'h0, 1'b1),
      chk_row(1'b1, 32'h0, 32'h0, 1'b1),
      // Zero dimensions act as one; full-scale stride wraps the source offset.
      cfg_row(CFG_NUM_DIMS, 64'h0),
      cfg_row(CFG_DIM_SIZES, 64'h0000_0000_0000_0003),
      cfg_row(CFG_IN_STRIDES_LOW, 64'h0000_0000_FFFF_FFFF),
      cfg_row(CFG_OUT_STRIDES_LOW, 64'h0000_0000_0000_0010),
      chk_row(1'b1, 32'h0, 32'h0, 1'b0),
      chk_row(1'b0, 32'hFFFF_FFFF, 32'h10, 1'b0),
      chk_row(1'b0, 32'hFFFF_FFFE, 32'h20, 1'b1),
      chk_row(1'b0, 32'h0, 32'h0, 1'b0),
      // A write to an unmapped index changes nothing.
      cfg_row(CFG_IDX_SPARE, 64'hFFFF_FFFF_FFFF_FFFF),
      chk_row(1'b0, 32'hFFFF_FFFF, 32'h10, 1'b0),
      // Seven dimensions saturate at four; dimension 0 shrinks below its coordinate.
      cfg_row(CFG_NUM_DIMS, 64'hFFFF_FFFF_FFFF_FFFF),
      cfg_row(CFG_DIM_SIZES, 64'h0002_0000_0003_0001),
      cfg_row(CFG_IN_STRIDES_LOW, 64'h0000_0100_0000_0001),
      cfg_row(CFG_IN_STRIDES_HIGH, 64'h0000_0010_8000_0000),
      cfg_row(CFG_OUT_STRIDES_LOW, 64'h0000_0004_0000_0040),
      cfg_row(CFG_OUT_STRIDES_HIGH, 64'hFFFF_FFFF_0000_1000),
      cfg_row(CFG_PERM_MAP, 64'h1E),
      req_row(1'b0), req_row(1'b0), req_row(1'b0), req_row(1'b0),
      req_row(1'b0), req_row(1'b0), req_row(1'b0), req_row(1'b1),
      // Every output dimension names an unused input dimension, so it reads zero.
      cfg_row(CFG_NUM_DIMS, 64'h2),
      cfg_row(CFG_PERM_MAP, 64'hFF),
      chk_row(1'b1, 32'h0, 32'h0, 1'b0),
      chk_row(1'b0, 32'h100, 32'h0, 1'b0),
      chk_row(1'b0, 32'h200, 32'h0, 1'b1),
      // Largest sizes on every dimension.
      cfg_row(CFG_DIM_SIZES, 64'hFFFF_FFFF_FFFF_FFFF),
      req_row(1'b0), req_row(1'b0)
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; register writes only once the pipeline is empty.
    directed_sent = 0;
    foreach (directed_table[i]) begin
      case (directed_table[i].kind)
        ROW_CFG: begin
          drain_pipeline();
          write_register(directed_table[i].index, directed_table[i].data);
          settings_count++;
        end
        ROW_REQ: begin
          send_request(directed_table[i].restart, 1'b0, '0);
          directed_sent++;
        end
        default: begin
          send_request(directed_table[i].restart, 1'b1, directed_table[i].result);
          directed_sent++;
        end
      endcase
    end

    // Random phases: a fresh setting, then a run of mostly plain advances.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_pipeline();
      randomise_config();
      burst = $urandom_range(20, 120);
      for (int k = 0; k < burst; k++) begin
        send_request(1'($urandom_range(0, 29) == 0), 1'b0, '0);
        if ((phase == 0 && k == 10) || $urandom_range(0, 199) == 0) drain_pipeline();
      end
      random_sent += burst;
      phase++;
    end

    drain_pipeline();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d directed and %0d random requests over %0d register settings.",
             directed_sent, random_sent, settings_count);
    $display("Checked %0d results, %0d of them flagged as the last element.",
             results_checked, last_flags_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/tpag_pkg.sv
rtl/tpag_odometer.sv
rtl/tensor_permute_address_gen.sv
dv/tensor_permute_address_gen_tb.sv
